// ===== hw/rtl/rcsed_pkg.sv =====
// Package for the radio-control switch edge decoder: payload types, register codes and constants.
package rcsed_pkg;

    // Pulse widths are in microseconds, timestamps in milliseconds.
    localparam int PULSE_W    = 12;
    localparam int DZ_W       = 11;
    localparam int TIME_W     = 32;
    localparam int CMD_MS_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [PULSE_W-1:0] CENTER_US    = PULSE_W'(1500);
    localparam logic [PULSE_W-1:0] RANGE_MAX_US = PULSE_W'(2100);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_THR     = 3'd0,
        REG_GEAR_THR     = 3'd1,
        REG_REBOOT_THR   = 3'd2,
        REG_TAKEOFF_THR  = 3'd3,
        REG_LAND_THR     = 3'd4,
        REG_STICK_DZ     = 3'd5,
        REG_THROTTLE_DZ  = 3'd6,
        REG_CMD_PULSE_MS = 3'd7
    } t_cfg_reg;

    // Register reset values.
    localparam logic [PULSE_W-1:0]  RST_MODE_THR     = PULSE_W'(1750);
    localparam logic [PULSE_W-1:0]  RST_GEAR_THR     = PULSE_W'(1750);
    localparam logic [PULSE_W-1:0]  RST_REBOOT_THR   = PULSE_W'(1500);
    localparam logic [PULSE_W-1:0]  RST_TAKEOFF_THR  = PULSE_W'(1250);
    localparam logic [PULSE_W-1:0]  RST_LAND_THR     = PULSE_W'(1750);
    localparam logic [DZ_W-1:0]     RST_STICK_DZ     = DZ_W'(125);
    localparam logic [DZ_W-1:0]     RST_THROTTLE_DZ  = DZ_W'(125);
    localparam logic [CMD_MS_W-1:0] RST_CMD_PULSE_MS = CMD_MS_W'(1000);

    // Takeoff/land flag bit positions.
    localparam int TL_TAKEOFF_TOG  = 0;
    localparam int TL_TAKEOFF_EXIT = 1;
    localparam int TL_LAND_TOG     = 2;
    localparam int TL_LAND_EXIT    = 3;

    // One radio-control frame.
    typedef struct packed {
        logic [PULSE_W-1:0] stick_roll;
        logic [PULSE_W-1:0] stick_pitch;
        logic [PULSE_W-1:0] stick_throttle;
        logic [PULSE_W-1:0] stick_yaw;
        logic [PULSE_W-1:0] mode_pulse;
        logic [PULSE_W-1:0] gear_pulse;
        logic [PULSE_W-1:0] reboot_pulse;
        logic [PULSE_W-1:0] takeoff_land_pulse;
        logic [TIME_W-1:0]  frame_time_ms;
    } t_rc_frame;

    // One decoded result.
    typedef struct packed {
        logic hover_mode;
        logic hover_entered;
        logic command_mode;
        logic command_entered;
        logic takeoff_toggle;
        logic takeoff_exit;
        logic land_toggle;
        logic land_exit;
        logic reboot_toggle;
        logic formation_toggle;
        logic sticks_centered;
        logic range_error;
    } t_rc_result;

endpackage

// ===== hw/rtl/rcsed_frame_if.sv =====
// Request channel interfaces for frames in and decoded results out.
interface rcsed_frame_if import rcsed_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rc_frame data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcsed_result_if import rcsed_pkg::*; ();
    logic       valid;
    logic       ready;
    t_rc_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rc_switch_edge_decoder_core.sv =====
// Radio-control switch edge decoder: one frame in, one result of mode levels and toggles out.
//
// Decodes one radio-control frame per clock cycle while results are taken as they appear. A
// frame request is taken whenever the result register is empty or its result is being taken
// in the same cycle, and its result is written into that register at the edge that takes the
// frame, so a held result that is not taken stalls new frames. Switch histories, the
// hover/command levels, the command entry timer and the takeoff/land flags update at the edge
// that takes a frame. The first frame after reset seeds the switch histories and shows no
// switch crossing. Configuration registers are written through the plain write port and
// should only be changed while no frame is in flight.
module rc_switch_edge_decoder_core import rcsed_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rcsed_frame_if.sink           i_frame_if,
    rcsed_result_if.source        o_result_if
);

    // Configuration registers.
    logic [PULSE_W-1:0]  r_mode_thr;
    logic [PULSE_W-1:0]  r_gear_thr;
    logic [PULSE_W-1:0]  r_reboot_thr;
    logic [PULSE_W-1:0]  r_takeoff_thr;
    logic [PULSE_W-1:0]  r_land_thr;
    logic [DZ_W-1:0]     r_stick_dz;
    logic [DZ_W-1:0]     r_throttle_dz;
    logic [CMD_MS_W-1:0] r_cmd_pulse_ms;

    // Decoder state.
    logic               r_seen_first;
    logic [PULSE_W-1:0] r_prev_mode;
    logic [PULSE_W-1:0] r_prev_gear;
    logic [PULSE_W-1:0] r_prev_reboot;
    logic [PULSE_W-1:0] r_prev_tl;
    logic               r_hover_level;
    logic               r_command_level;
    logic               r_command_flag;
    logic [TIME_W-1:0]  r_command_start;
    logic [3:0]         r_tl_flags;

    // Result register.
    logic       r_out_valid;
    t_rc_result r_out;

    // Next values.
    logic               n_hover_level;
    logic               n_command_level;
    logic               n_command_flag;
    logic [TIME_W-1:0]  n_command_start;
    logic [3:0]         n_tl_flags;
    t_rc_result         n_out;

    // Working signals.
    t_rc_frame          frame;
    logic               accept;
    logic [PULSE_W-1:0] prev_mode;
    logic [PULSE_W-1:0] prev_gear;
    logic [PULSE_W-1:0] prev_reboot;
    logic [PULSE_W-1:0] prev_tl;
    logic               gear_rise;
    logic               cmd_flag_mid;
    logic [TIME_W-1:0]  cmd_start_mid;
    logic [TIME_W-1:0]  elapsed;
    logic               formation;

    // Distance of a stick pulse from center, compared strictly against a dead zone.
    function automatic logic stick_within(input logic [PULSE_W-1:0] p,
                                          input logic [DZ_W-1:0] dz);
        logic [PULSE_W-1:0] d;
        d = (p > CENTER_US) ? (p - CENTER_US) : (CENTER_US - p);
        return d < {1'b0, dz};
    endfunction

    assign frame  = i_frame_if.data;
    assign accept = i_frame_if.valid && i_frame_if.ready;

    // A new frame is taken while the result register is free or being drained.
    assign i_frame_if.ready  = !r_out_valid || o_result_if.ready;
    assign o_result_if.valid = r_out_valid;
    assign o_result_if.data  = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_thr     <= RST_MODE_THR;
            r_gear_thr     <= RST_GEAR_THR;
            r_reboot_thr   <= RST_REBOOT_THR;
            r_takeoff_thr  <= RST_TAKEOFF_THR;
            r_land_thr     <= RST_LAND_THR;
            r_stick_dz     <= RST_STICK_DZ;
            r_throttle_dz  <= RST_THROTTLE_DZ;
            r_cmd_pulse_ms <= RST_CMD_PULSE_MS;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MODE_THR:     r_mode_thr     <= i_cfg_data[PULSE_W-1:0];
                REG_GEAR_THR:     r_gear_thr     <= i_cfg_data[PULSE_W-1:0];
                REG_REBOOT_THR:   r_reboot_thr   <= i_cfg_data[PULSE_W-1:0];
                REG_TAKEOFF_THR:  r_takeoff_thr  <= i_cfg_data[PULSE_W-1:0];
                REG_LAND_THR:     r_land_thr     <= i_cfg_data[PULSE_W-1:0];
                REG_STICK_DZ:     r_stick_dz     <= i_cfg_data[DZ_W-1:0];
                REG_THROTTLE_DZ:  r_throttle_dz  <= i_cfg_data[DZ_W-1:0];
                REG_CMD_PULSE_MS: r_cmd_pulse_ms <= i_cfg_data[CMD_MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The first frame sees its own pulses as history, so it shows no crossing.
    always_comb begin
        prev_mode   = r_seen_first ? r_prev_mode   : frame.mode_pulse;
        prev_gear   = r_seen_first ? r_prev_gear   : frame.gear_pulse;
        prev_reboot = r_seen_first ? r_prev_reboot : frame.reboot_pulse;
        prev_tl     = r_seen_first ? r_prev_tl     : frame.takeoff_land_pulse;
    end

    // Takeoff/land crossings, judged only if the previous frame was hovering.
    always_comb begin
        n_tl_flags = r_tl_flags;
        if (r_hover_level) begin
            n_tl_flags = '0;
            if (prev_tl > r_takeoff_thr && frame.takeoff_land_pulse < r_takeoff_thr) begin
                n_tl_flags[TL_TAKEOFF_TOG] = 1'b1;
            end else if (prev_tl < r_takeoff_thr &&
                         frame.takeoff_land_pulse > r_takeoff_thr) begin
                n_tl_flags[TL_TAKEOFF_EXIT] = 1'b1;
            end else if (prev_tl < r_land_thr && frame.takeoff_land_pulse > r_land_thr) begin
                n_tl_flags[TL_LAND_TOG] = 1'b1;
            end else if (prev_tl > r_land_thr && frame.takeoff_land_pulse < r_land_thr) begin
                n_tl_flags[TL_LAND_EXIT] = 1'b1;
            end
        end
    end

    // Hover and command levels, and the command entry flag with its timeout.
    always_comb begin
        n_hover_level   = frame.mode_pulse > r_mode_thr;
        gear_rise       = prev_gear < r_gear_thr && frame.gear_pulse > r_gear_thr;
        n_command_level = r_command_level;
        cmd_flag_mid    = r_command_flag;
        cmd_start_mid   = r_command_start;
        if (n_hover_level) begin
            if (gear_rise) begin
                cmd_start_mid = frame.frame_time_ms;
                cmd_flag_mid  = 1'b1;
            end else if (frame.gear_pulse < r_gear_thr) begin
                cmd_flag_mid = 1'b0;
            end
            n_command_level = frame.gear_pulse > r_gear_thr;
        end
        elapsed         = frame.frame_time_ms - cmd_start_mid;
        n_command_flag  = cmd_flag_mid && !(elapsed > {{(TIME_W-CMD_MS_W){1'b0}},
                                                       r_cmd_pulse_ms});
        n_command_start = cmd_start_mid;
    end

    // Assemble the result.
    always_comb begin
        formation               = prev_reboot < r_reboot_thr &&
                                  frame.reboot_pulse > r_reboot_thr;
        n_out.hover_mode        = n_hover_level;
        n_out.hover_entered     = prev_mode < r_mode_thr && frame.mode_pulse > r_mode_thr;
        n_out.command_mode      = n_command_level;
        n_out.command_entered   = n_command_flag;
        n_out.takeoff_toggle    = n_tl_flags[TL_TAKEOFF_TOG];
        n_out.takeoff_exit      = n_tl_flags[TL_TAKEOFF_EXIT];
        n_out.land_toggle       = n_tl_flags[TL_LAND_TOG];
        n_out.land_exit         = n_tl_flags[TL_LAND_EXIT];
        n_out.reboot_toggle     = !n_hover_level && !n_command_level && formation;
        n_out.formation_toggle  = formation;
        n_out.sticks_centered   = stick_within(frame.stick_roll, r_stick_dz) &&
                                  stick_within(frame.stick_pitch, r_stick_dz) &&
                                  stick_within(frame.stick_throttle, r_throttle_dz) &&
                                  stick_within(frame.stick_yaw, r_stick_dz);
        n_out.range_error       = frame.mode_pulse > RANGE_MAX_US ||
                                  frame.gear_pulse > RANGE_MAX_US ||
                                  frame.reboot_pulse > RANGE_MAX_US;
    end

    // Decoder state advances on each accepted frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first    <= 1'b0;
            r_prev_mode     <= '0;
            r_prev_gear     <= '0;
            r_prev_reboot   <= '0;
            r_prev_tl       <= '0;
            r_hover_level   <= 1'b1;
            r_command_level <= 1'b1;
            r_command_flag  <= 1'b0;
            r_command_start <= '0;
            r_tl_flags      <= '0;
        end else if (accept) begin
            r_seen_first    <= 1'b1;
            r_prev_mode     <= frame.mode_pulse;
            r_prev_gear     <= frame.gear_pulse;
            r_prev_reboot   <= frame.reboot_pulse;
            r_prev_tl       <= frame.takeoff_land_pulse;
            r_hover_level   <= n_hover_level;
            r_command_level <= n_command_level;
            r_command_flag  <= n_command_flag;
            r_command_start <= n_command_start;
            r_tl_flags      <= n_tl_flags;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // At most one takeoff/land flag is ever held.
    a_tl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_tl_flags))
        else $error("more than one takeoff/land flag set");

    // A reboot toggle is always also a formation toggle.
    a_reboot_formation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.reboot_toggle |-> r_out.formation_toggle)
        else $error("reboot toggle without formation toggle");

    // Hover entry is only reported together with the hover level.
    a_hover_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.hover_entered |-> r_out.hover_mode)
        else $error("hover entry outside hover mode");

    // An accepted frame always leaves a result and seeds the history.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid && r_seen_first)
        else $error("accepted frame left no result");
`endif

endmodule
